/* rtl/wcs_pkg.sv */
// Package with the CRC-32 constants, widths and byte update functions of the shingle hasher.
`timescale 1ns / 1ps

package wcs_pkg;

  localparam int MAX_WINDOW_DEFAULT = 16;
  localparam int SYMBOL_W = 8;
  localparam int HASH_W = 32;
  localparam int SHINGLE_LEN_W = 5;
  localparam logic [SHINGLE_LEN_W-1:0] SHINGLE_LEN_RESET = 5'd8;

  localparam logic [HASH_W-1:0] CRC_POLY_REFLECTED = 32'hEDB88320;
  localparam logic [HASH_W-1:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [HASH_W-1:0] CRC_XOROUT = 32'hFFFFFFFF;

  // Table entry for one byte index: eight bit steps of the reflected CRC.
  function automatic logic [HASH_W-1:0] crc_table(input logic [SYMBOL_W-1:0] idx);
    logic [HASH_W-1:0] c;
    c = {{(HASH_W - SYMBOL_W){1'b0}}, idx};
    for (int k = 0; k < SYMBOL_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFLECTED;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Absorbs one byte into a running CRC.
  function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc,
                                                 input logic [SYMBOL_W-1:0] b);
    return (crc >> SYMBOL_W) ^ crc_table(crc[SYMBOL_W-1:0] ^ b);
  endfunction

endpackage

/* rtl/wcs_if.sv */
// Valid/ready channel interfaces for the input characters and the result words.
`timescale 1ns / 1ps

interface wcs_in_if;
  logic valid;
  logic ready;
  logic [wcs_pkg::SYMBOL_W-1:0] symbol;
  logic last_of_sequence;

  modport source (output valid, output symbol, output last_of_sequence, input ready);
  modport sink (input valid, input symbol, input last_of_sequence, output ready);
endinterface

interface wcs_out_if;
  logic valid;
  logic ready;
  logic hash_valid;
  logic [wcs_pkg::HASH_W-1:0] shingle_hash;
  logic sequence_end;

  modport source (output valid, output hash_valid, output shingle_hash, output sequence_end,
                  input ready);
  modport sink (input valid, input hash_valid, input shingle_hash, input sequence_end,
                output ready);
endinterface

/* rtl/wcs_cell.sv */
// One cell of the CRC chain: holds the running CRC of the window that started at its depth.
`timescale 1ns / 1ps

module wcs_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [wcs_pkg::HASH_W-1:0]   crc_in,
  input  logic [wcs_pkg::SYMBOL_W-1:0] symbol,
  output logic [wcs_pkg::HASH_W-1:0]   crc_next,
  output logic [wcs_pkg::HASH_W-1:0]   crc
);

  assign crc_next = wcs_pkg::crc_byte(crc_in, symbol);

  always_ff @(posedge clk) begin
    if (en) begin
      crc <= crc_next;
    end
  end

endmodule

/* rtl/window_crc32_shingler.sv */
// Top level of the sliding-window CRC-32 shingle hasher.
`timescale 1ns / 1ps

// The block takes one character per clock cycle as long as its result words are
// taken as they appear, and returns one result word per character in the cycle after
// it is accepted, from an output register. A character is accepted only when that
// register is empty or its word is taken in the same cycle, so a result that waits
// stalls the input until it is taken. A row of
// MAX_WINDOW cells holds the running CRC-32 of every window that ends at the
// newest character; on each accepted character every cell absorbs the new byte into the CRC its
// neighbor held, so the hash of the last shingle_len characters is the output of
// cell shingle_len-1. The result hash is valid once the current sequence has at
// least shingle_len characters; otherwise hash_valid and shingle_hash are zero.
// There is no clearing pass after reset.
module window_crc32_shingler #(
  parameter int MAX_WINDOW = wcs_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wcs_pkg::SHINGLE_LEN_W-1:0] cfg_data,
  wcs_in_if.sink                           din,
  wcs_out_if.source                        dout
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W = (CNT_W > wcs_pkg::SHINGLE_LEN_W) ? CNT_W : wcs_pkg::SHINGLE_LEN_W;

  logic [wcs_pkg::SHINGLE_LEN_W-1:0] shingle_len;
  logic [CNT_W-1:0]                  fill_count;
  logic [CNT_W-1:0]                  fill_inc;
  logic [CNT_W-1:0]                  fill_count_next;
  logic [CMP_W-1:0]                  len_ext;
  logic [CMP_W-1:0]                  eff_len;
  logic [IDX_W-1:0]                  sel;
  logic                              accept;
  logic                              window_full;

  logic [wcs_pkg::HASH_W-1:0] cell_crc  [MAX_WINDOW];
  logic [wcs_pkg::HASH_W-1:0] cell_next [MAX_WINDOW];

  assign accept = din.valid && din.ready;
  assign din.ready = !dout.valid || dout.ready;

  genvar i;
  generate
    for (i = 0; i < MAX_WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
        wcs_cell u_cell (
          .clk      (clk),
          .en       (accept),
          .crc_in   (wcs_pkg::CRC_INIT),
          .symbol   (din.symbol),
          .crc_next (cell_next[i]),
          .crc      (cell_crc[i])
        );
      end else begin : g_body
        wcs_cell u_cell (
          .clk      (clk),
          .en       (accept),
          .crc_in   (cell_crc[i-1]),
          .symbol   (din.symbol),
          .crc_next (cell_next[i]),
          .crc      (cell_crc[i])
        );
      end
    end
  endgenerate

  always_comb begin
    len_ext = CMP_W'(shingle_len);
    if (len_ext == '0) begin
      eff_len = CMP_W'(1);
    end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
      eff_len = CMP_W'(MAX_WINDOW);
    end else begin
      eff_len = len_ext;
    end
    sel = IDX_W'(eff_len - CMP_W'(1));
    if (fill_count == CNT_W'(MAX_WINDOW)) begin
      fill_inc = fill_count;
    end else begin
      fill_inc = fill_count + CNT_W'(1);
    end
    window_full = CMP_W'(fill_inc) >= eff_len;
    fill_count_next = din.last_of_sequence ? '0 : fill_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shingle_len <= wcs_pkg::SHINGLE_LEN_RESET;
      fill_count <= '0;
      dout.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        shingle_len <= cfg_data;
      end
      if (accept) begin
        fill_count <= fill_count_next;
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dout.hash_valid <= window_full;
      dout.shingle_hash <= window_full ? (cell_next[sel] ^ wcs_pkg::CRC_XOROUT) : '0;
      dout.sequence_end <= din.last_of_sequence;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(MAX_WINDOW))
    else $error("fill count above window depth");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && din.last_of_sequence |=> fill_count == '0)
    else $error("fill count did not restart after the last character");

  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> dout.valid && dout.sequence_end == $past(din.last_of_sequence))
    else $error("accepted character gave no result word");

  a_no_hash_zero: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.hash_valid |-> dout.shingle_hash == '0)
    else $error("hash not zero without a full window");

  a_first_char: assert property (@(posedge clk) disable iff (rst)
    accept && fill_count == '0 && eff_len > CMP_W'(1) |=> !dout.hash_valid)
    else $error("hash flagged on the first character of a sequence");
`endif

endmodule
